// ===== hdl/fcp_pkg.sv =====
// Shared types and constants for the circular FIFO with peek.
package fcp_pkg;

    localparam int SLOTS     = 256;
    localparam int WORD_W    = 32;
    localparam int ADDR_W    = $clog2(SLOTS);
    localparam int RING_W    = ADDR_W + 1;
    localparam int CAP_W     = 8;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 8'd255;

    localparam logic [MODE_W-1:0] MODE_PUT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GET  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [WORD_W-1:0] value;
        logic [ADDR_W-1:0]        slot_index;
    } t_in_beat;

    typedef struct packed {
        logic signed [WORD_W-1:0] data;
        logic [STATUS_W-1:0]      status;
        logic [CAP_W-1:0]         occupancy;
    } t_out_beat;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] waddr;
        logic [ADDR_W-1:0] raddr;
        logic [WORD_W-1:0] wdata;
    } t_mem_req;

    typedef struct packed {
        logic                use_rdata;
        logic [STATUS_W-1:0] status;
        logic [CAP_W-1:0]    occupancy;
    } t_resp_meta;

endpackage

// ===== hdl/fcp_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
module fcp_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/fcp_ctrl.sv =====
// Pointer control: decode each beat, check full/empty/range, drive the RAM.
module fcp_ctrl
    import fcp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    input  t_in_beat         i_in_beat,
    input  logic             i_free,
    output logic             o_fire,
    output t_mem_req         o_mem,
    output t_resp_meta       o_meta
);

    logic [CAP_W-1:0]  r_cap;
    logic [ADDR_W-1:0] r_rp, n_rp;
    logic [ADDR_W-1:0] r_wp, n_wp;

    logic [RING_W-1:0] ring;
    logic [RING_W-1:0] level;
    logic [RING_W-1:0] idx_ext;
    logic [ADDR_W-1:0] rp_inc;
    logic [ADDR_W-1:0] wp_inc;
    logic              is_full;
    logic              ring_empty;
    logic              live;

    assign o_fire  = i_in_valid && i_free;
    assign ring    = {1'b0, r_cap} + RING_W'(1);
    assign idx_ext = {1'b0, i_in_beat.slot_index};

    always_comb begin
        if (r_wp >= r_rp) begin
            level = {1'b0, r_wp} - {1'b0, r_rp};
        end else begin
            level = {1'b0, r_wp} + ring - {1'b0, r_rp};
        end
    end

    assign is_full    = (level >= {1'b0, r_cap});
    assign ring_empty = (level == '0);

    // wrap at the ring size, not the RAM depth
    assign rp_inc = (({1'b0, r_rp} + RING_W'(1)) >= ring) ? '0 : r_rp + ADDR_W'(1);
    assign wp_inc = (({1'b0, r_wp} + RING_W'(1)) >= ring) ? '0 : r_wp + ADDR_W'(1);

    always_comb begin
        if (r_rp < r_wp) begin
            live = (i_in_beat.slot_index >= r_rp) && (i_in_beat.slot_index < r_wp);
        end else begin
            live = (i_in_beat.slot_index < r_wp)
                || ((i_in_beat.slot_index >= r_rp) && (idx_ext < ring));
        end
    end

    always_comb begin
        n_rp                = r_rp;
        n_wp                = r_wp;
        o_mem.we            = 1'b0;
        o_mem.re            = 1'b0;
        o_mem.waddr         = r_wp;
        o_mem.raddr         = r_rp;
        o_mem.wdata         = i_in_beat.value;
        o_meta.use_rdata    = 1'b0;
        o_meta.status       = ST_OK;
        o_meta.occupancy    = level[CAP_W-1:0];
        case (i_in_beat.mode)
            MODE_PUT: begin
                if (is_full) begin
                    o_meta.status = ST_FULL;
                end else begin
                    o_mem.we         = o_fire;
                    n_wp             = wp_inc;
                    o_meta.occupancy = level[CAP_W-1:0] + CAP_W'(1);
                end
            end
            MODE_GET: begin
                if (ring_empty) begin
                    o_meta.status = ST_EMPTY;
                end else begin
                    o_mem.re         = o_fire;
                    o_meta.use_rdata = 1'b1;
                    n_rp             = rp_inc;
                    o_meta.occupancy = level[CAP_W-1:0] - CAP_W'(1);
                end
            end
            MODE_PEEK: begin
                o_mem.raddr = i_in_beat.slot_index;
                if (ring_empty) begin
                    o_meta.status = ST_EMPTY;
                end else if (live) begin
                    o_mem.re         = o_fire;
                    o_meta.use_rdata = 1'b1;
                end else begin
                    o_meta.status = ST_RANGE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
            r_rp  <= '0;
            r_wp  <= '0;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
            r_rp  <= '0;
            r_wp  <= '0;
        end else if (o_fire) begin
            r_rp <= n_rp;
            r_wp <= n_wp;
        end
    end

endmodule

// ===== hdl/fcp_resp.sv =====
// Response path: RAM read stage and output register with stall handling.
module fcp_resp
    import fcp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  t_resp_meta        i_meta,
    input  logic [WORD_W-1:0] i_rdata,
    input  logic              i_out_stall,
    output logic              o_free,
    output logic              o_out_valid,
    output t_out_beat         o_out_beat
);

    logic       r_s1_valid;
    t_resp_meta r_s1_meta;
    logic       r_out_valid;
    t_out_beat  r_out_beat;
    logic       move;

    assign move   = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_free = !r_s1_valid || move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_free) begin
                r_s1_valid <= i_fire;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_fire) begin
            r_s1_meta <= i_meta;
        end
        if (move) begin
            r_out_beat.data      <= r_s1_meta.use_rdata ? i_rdata : '0;
            r_out_beat.status    <= r_s1_meta.status;
            r_out_beat.occupancy <= r_s1_meta.occupancy;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

// ===== hdl/circular_fifo_with_peek.sv =====
// Circular FIFO of signed 32-bit words with put, get and peek at a physical slot.
// The ring holds capacity+1 slots in a 256-entry synchronous RAM, so one slot
// always stays empty. Each input beat carries one operation and yields exactly
// one result beat with data, status and the occupancy after the operation. A
// beat is taken every cycle while the read stage can advance: pointers live in
// registers and are updated at the accepting edge, so the next beat sees them
// at once; the RAM is written or read in that same cycle, its registered read
// data is picked up when the read stage advances, and an output register
// follows. A refused put (full) or get (empty) changes nothing; peeks outside
// the live region of a non-empty buffer return status out-of-range with zero
// data. Writing capacity empties the buffer; write it only while idle. No
// clearing pass is needed after reset.
module circular_fifo_with_peek
    import fcp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_beat         i_in_beat,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_beat        o_out_beat
);

    t_mem_req          mem_req;
    t_resp_meta        meta;
    logic              fire;
    logic              free;
    logic [WORD_W-1:0] rdata;

    // hold the input side while the read stage cannot advance
    assign o_in_stall = !free;

    fcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_beat  (i_in_beat),
        .i_free     (free),
        .o_fire     (fire),
        .o_mem      (mem_req),
        .o_meta     (meta)
    );

    // storage: one write and one read per cycle, read data registered
    fcp_ram #(
        .DEPTH (SLOTS),
        .WIDTH (WORD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (rdata)
    );

    fcp_resp u_resp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_meta      (meta),
        .i_rdata     (rdata),
        .i_out_stall (i_out_stall),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat)
    );

endmodule

// ===== hdl/fcp_checker.sv =====
// Port-level checker for the circular FIFO, bound to the top level.
module fcp_checker
    import fcp_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input t_out_beat        o_out_beat
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("result beat dropped or changed under stall");

    a_reset_idle: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result beat valid straight after reset");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.status != ST_OK) |-> o_out_beat.data == '0)
        else $error("refused operation returned non-zero data");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_beat.status == ST_EMPTY) |-> o_out_beat.occupancy == '0)
        else $error("empty status with non-zero occupancy");

endmodule

bind circular_fifo_with_peek fcp_checker u_checker (.*);
